// File: hdl/i2c_master_byte_engine_unit_assert.svh
// Assertion macros shared by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/i2cm_pkg.sv
// Types and constants of the I2C master byte engine.
package i2cm_pkg;

    // Command codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // Line phases, one-hot
    typedef enum logic [15:0] {
        PH_IDLE  = 16'h0001,
        PH_ST1   = 16'h0002,
        PH_ST2   = 16'h0004,
        PH_ST3   = 16'h0008,
        PH_SP1   = 16'h0010,
        PH_SP2   = 16'h0020,
        PH_WSET  = 16'h0040,
        PH_WHIGH = 16'h0080,
        PH_WLOW  = 16'h0100,
        PH_AK1   = 16'h0200,
        PH_AK2   = 16'h0400,
        PH_POLL  = 16'h0800,
        PH_RLOW  = 16'h1000,
        PH_RHIGH = 16'h2000,
        PH_K1    = 16'h4000,
        PH_K2    = 16'h8000
    } t_phase;

    typedef struct packed {
        logic [7:0] short_len;
        logic [7:0] long_len;
        logic [7:0] timeout;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{short_len: 8'd4, long_len: 8'd10, timeout: 8'd250};

    typedef struct packed {
        t_phase     phase;
        logic [7:0] tick_cnt;
        logic [7:0] poll_cnt;
        logic [3:0] bit_cnt;
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       ack_choice;
        logic       ack_error;
        logic [7:0] rx_hold;
    } t_eng_state;

    localparam t_eng_state ENG_RESET = '{
        phase: PH_IDLE, tick_cnt: 8'd0, poll_cnt: 8'd0, bit_cnt: 4'd0, shift: 8'd0,
        scl: 1'b1, sda: 1'b1, ack_choice: 1'b0, ack_error: 1'b0, rx_hold: 8'd0
    };

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } t_result;

endpackage

// File: hdl/i2cm_cmd_if.sv
// Tick/command channel of the I2C master byte engine.
interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, output opcode, output tx_byte, output send_ack,
                    output sda_in, input ready);
    modport sink   (input valid, input opcode, input tx_byte, input send_ack,
                    input sda_in, output ready);
endinterface

// File: hdl/i2cm_res_if.sv
// Result channel of the I2C master byte engine.
interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output rx_byte, output ack_missing, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input rx_byte, input ack_missing, output ready);
endinterface

// File: hdl/i2cm_cfg_regs.sv
// Configuration register bank: phase lengths and ACK timeout.
module i2cm_cfg_regs
    import i2cm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Indexed write; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHORT:   r_cfg.short_len <= i_cfg_data;
                CFG_LONG:    r_cfg.long_len  <= i_cfg_data;
                CFG_TIMEOUT: r_cfg.timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/i2cm_step.sv
// Next-state and result logic for one time-base tick.
module i2cm_step
    import i2cm_pkg::*;
(
    input  t_eng_state i_state,
    input  t_cfg       i_cfg,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    output t_eng_state o_state,
    output t_result    o_res
);

    // Enter a phase with new line levels and a fresh tick count
    function automatic t_eng_state f_set(t_eng_state st, t_phase ph, logic scl, logic sda);
        t_eng_state r;
        r          = st;
        r.phase    = ph;
        r.scl      = scl;
        r.sda      = sda;
        r.tick_cnt = 8'd0;
        return r;
    endfunction

    t_eng_state n_st;
    logic       done;
    logic [7:0] tick_inc;
    logic [3:0] bit_inc;
    logic [7:0] shl;
    logic [7:0] len;
    logic       is_long;

    assign tick_inc = i_state.tick_cnt + 8'd1;
    assign bit_inc  = i_state.bit_cnt + 4'd1;
    assign shl      = {i_state.shift[6:0], 1'b0};
    assign is_long  = (i_state.phase == PH_WSET) || (i_state.phase == PH_WHIGH) ||
                      (i_state.phase == PH_WLOW) || (i_state.phase == PH_RLOW) ||
                      (i_state.phase == PH_RHIGH);
    assign len      = is_long ? i_cfg.long_len : i_cfg.short_len;

    always_comb begin
        n_st = i_state;
        done = 1'b0;
        if (i_state.phase == PH_IDLE) begin
            // Command decode, idle only
            unique case (i_opcode)
                OP_START: n_st = f_set(i_state, PH_ST1, 1'b1, 1'b1);
                OP_STOP:  n_st = f_set(i_state, PH_SP1, 1'b0, 1'b0);
                OP_WRITE: begin
                    n_st         = i_state;
                    n_st.shift   = i_tx_byte;
                    n_st.bit_cnt = 4'd0;
                    n_st         = f_set(n_st, PH_WSET, 1'b0, i_tx_byte[7]);
                end
                OP_READ: begin
                    n_st            = i_state;
                    n_st.ack_choice = i_send_ack;
                    n_st.shift      = 8'd0;
                    n_st.bit_cnt    = 4'd0;
                    n_st            = f_set(n_st, PH_RLOW, 1'b0, 1'b1);
                end
                OP_NONE: ;
                default: ;
            endcase
        end else if (i_state.phase == PH_POLL) begin
            // ACK poll: low ends the write, too many highs forces a stop
            if (!i_sda_in) begin
                n_st.ack_error = 1'b0;
                n_st           = f_set(n_st, PH_IDLE, 1'b0, 1'b1);
                done           = 1'b1;
            end else if (i_state.poll_cnt >= i_cfg.timeout) begin
                n_st.ack_error = 1'b1;
                n_st           = f_set(n_st, PH_SP1, 1'b0, 1'b0);
            end else begin
                n_st.poll_cnt = i_state.poll_cnt + 8'd1;
            end
        end else if (tick_inc < len) begin
            n_st.tick_cnt = tick_inc;
        end else begin
            // Phase timer expired: move to the next phase
            unique case (i_state.phase)
                PH_ST1:   n_st = f_set(i_state, PH_ST2, 1'b1, 1'b0);
                PH_ST2:   n_st = f_set(i_state, PH_ST3, 1'b1, 1'b0);
                PH_SP1:   n_st = f_set(i_state, PH_SP2, 1'b1, 1'b1);
                PH_WSET:  n_st = f_set(i_state, PH_WHIGH, 1'b1, i_state.sda);
                PH_WHIGH: n_st = f_set(i_state, PH_WLOW, 1'b0, i_state.sda);
                PH_WLOW: begin
                    n_st.shift   = shl;
                    n_st.bit_cnt = bit_inc;
                    if (bit_inc < 4'd8) begin
                        n_st = f_set(n_st, PH_WSET, 1'b0, shl[7]);
                    end else begin
                        n_st = f_set(n_st, PH_AK1, 1'b0, 1'b1);
                    end
                end
                PH_AK1:   n_st = f_set(i_state, PH_AK2, 1'b1, 1'b1);
                PH_AK2: begin
                    n_st.poll_cnt = 8'd0;
                    n_st          = f_set(n_st, PH_POLL, 1'b1, 1'b1);
                end
                PH_RLOW: begin
                    n_st.shift = {i_state.shift[6:0], i_sda_in};
                    n_st       = f_set(n_st, PH_RHIGH, 1'b1, 1'b1);
                end
                PH_RHIGH: begin
                    n_st.bit_cnt = bit_inc;
                    if (bit_inc < 4'd8) begin
                        n_st = f_set(n_st, PH_RLOW, 1'b0, 1'b1);
                    end else begin
                        n_st.rx_hold = i_state.shift;
                        n_st = f_set(n_st, PH_K1, 1'b0, !i_state.ack_choice);
                    end
                end
                PH_K1:    n_st = f_set(i_state, PH_K2, 1'b1, i_state.sda);
                PH_ST3, PH_K2: begin
                    n_st = f_set(i_state, PH_IDLE, 1'b0, i_state.sda);
                    done = 1'b1;
                end
                PH_SP2: begin
                    n_st = f_set(i_state, PH_IDLE, 1'b1, 1'b1);
                    done = 1'b1;
                end
                default: begin
                    n_st = f_set(i_state, PH_IDLE, i_state.scl, i_state.sda);
                    done = 1'b1;
                end
            endcase
        end
    end

    assign o_state           = n_st;
    assign o_res.scl_out     = n_st.scl;
    assign o_res.sda_out     = n_st.sda;
    assign o_res.busy_res    = (n_st.phase != PH_IDLE);
    assign o_res.done_res    = done;
    assign o_res.rx_byte     = n_st.rx_hold;
    assign o_res.ack_missing = n_st.ack_error;

endmodule

// File: hdl/i2c_master_byte_engine_unit.sv
// I2C master byte engine. Each item on i_item is one time-base tick carrying an optional
// command (start, stop, write byte with ACK poll, read byte with ACK/NACK) and the sampled
// SDA level; each tick yields one result item with the SCL/SDA levels after that tick,
// busy/done flags, the last received byte and the missing-ACK flag. The engine takes one
// tick per clock: the phase sequencer updates in the cycle the tick is accepted and the
// result appears in the output register on the next cycle. A stalled output register holds
// off further ticks until it is taken, at which point a new tick is accepted in the same
// cycle. Configuration registers (phase lengths, ACK timeout) are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write them only while no command is in progress (the block does not check); index 3 is ignored.
`include "i2c_master_byte_engine_unit_assert.svh"

module i2c_master_byte_engine_unit
    import i2cm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    i2cm_cmd_if.sink             i_item,
    i2cm_res_if.source           o_result
);

    t_cfg       cfg;
    t_eng_state r_state;
    t_eng_state n_state;
    t_result    n_res;
    t_result    r_res;
    logic       r_res_valid;
    logic       acc;

    i2cm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    i2cm_step u_step (
        .i_state    (r_state),
        .i_cfg      (cfg),
        .i_opcode   (i_item.opcode),
        .i_tx_byte  (i_item.tx_byte),
        .i_send_ack (i_item.send_ack),
        .i_sda_in   (i_item.sda_in),
        .o_state    (n_state),
        .o_res      (n_res)
    );

    // Accept whenever the output register is empty or being drained
    assign i_item.ready = !r_res_valid || o_result.ready;
    assign acc          = i_item.valid && i_item.ready;

    // Engine state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ENG_RESET;
            r_res_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_state <= n_state;
            end
            if (acc) begin
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid       = r_res_valid;
    assign o_result.scl_out     = r_res.scl_out;
    assign o_result.sda_out     = r_res.sda_out;
    assign o_result.busy_res    = r_res.busy_res;
    assign o_result.done_res    = r_res.done_res;
    assign o_result.rx_byte     = r_res.rx_byte;
    assign o_result.ack_missing = r_res.ack_missing;

    // Checks
    `I2CM_ASSERT_NOW(a_idle_tick_zero, r_state.phase == PH_IDLE, r_state.tick_cnt == 8'd0, "tick count not cleared in idle")
    `I2CM_ASSERT_NOW(a_bit_cnt_range, 1'b1, r_state.bit_cnt <= 4'd8, "bit count beyond a byte")
    `I2CM_ASSERT_NOW(a_done_not_busy, r_res_valid && r_res.done_res, !r_res.busy_res, "done while busy")
    `I2CM_ASSERT_NEXT(a_start_levels, acc && (r_state.phase == PH_IDLE) && (i_item.opcode == OP_START), r_res_valid && r_res.scl_out && r_res.sda_out && r_res.busy_res, "start not shown")
    `I2CM_ASSERT_NEXT(a_poll_ack, acc && (r_state.phase == PH_POLL) && !i_item.sda_in, r_res.done_res && !r_res.ack_missing && !r_res.scl_out, "ACK not taken")

endmodule

// File: tb/i2cm_line_checker.sv
// Checker for the I2C master byte engine: predicts each tick's result item and compares.
module i2cm_line_checker
    import i2cm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    i2cm_cmd_if                  i_tick,
    i2cm_res_if                  i_res,
    output int                   o_err_cnt,
    output int                   o_pending,
    output logic                 o_busy
);

    // Predicted engine state and register copy
    t_cfg       cfg;
    t_phase     ph;
    logic [7:0] tick_cnt;
    logic [7:0] poll_cnt;
    logic [3:0] bit_cnt;
    logic [7:0] shifter;
    logic       scl_lvl;
    logic       sda_lvl;
    logic       ack_sel;
    logic       ack_err;
    logic [7:0] rx_last;

    t_result    owed_results[$];
    t_result    want;
    int         err_n = 0;

    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_n++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp);
        if (got !== exp) begin
            report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp));
        end
    endtask

    function automatic void move_to(input t_phase p, input logic scl, input logic sda);
        ph       = p;
        scl_lvl  = scl;
        sda_lvl  = sda;
        tick_cnt = 8'd0;
    endfunction

    // Data bit phases use the long length, everything else the short one
    function automatic logic [7:0] phase_ticks(input t_phase p);
        case (p)
            PH_WSET, PH_WHIGH, PH_WLOW, PH_RLOW, PH_RHIGH: return cfg.long_len;
            default: return cfg.short_len;
        endcase
    endfunction

    // Leave the current timed phase; returns 1 when the command completes
    function automatic logic end_phase(input logic sda_smp);
        logic fin;
        fin = 1'b0;
        case (ph)
            PH_ST1:   move_to(PH_ST2, 1'b1, 1'b0);
            PH_ST2:   move_to(PH_ST3, 1'b1, 1'b0);
            PH_SP1:   move_to(PH_SP2, 1'b1, 1'b1);
            PH_WSET:  move_to(PH_WHIGH, 1'b1, sda_lvl);
            PH_WHIGH: move_to(PH_WLOW, 1'b0, sda_lvl);
            PH_WLOW: begin
                shifter = {shifter[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < 4'd8) move_to(PH_WSET, 1'b0, shifter[7]);
                else move_to(PH_AK1, 1'b0, 1'b1);
            end
            PH_AK1:   move_to(PH_AK2, 1'b1, 1'b1);
            PH_AK2: begin
                move_to(PH_POLL, 1'b1, 1'b1);
                poll_cnt = 8'd0;
            end
            // bit is taken on the tick SCL rises
            PH_RLOW: begin
                move_to(PH_RHIGH, 1'b1, 1'b1);
                shifter = {shifter[6:0], sda_smp};
            end
            PH_RHIGH: begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < 4'd8) begin
                    move_to(PH_RLOW, 1'b0, 1'b1);
                end else begin
                    rx_last = shifter;
                    move_to(PH_K1, 1'b0, !ack_sel);
                end
            end
            PH_K1:    move_to(PH_K2, 1'b1, sda_lvl);
            PH_ST3, PH_K2: begin
                move_to(PH_IDLE, 1'b0, sda_lvl);
                fin = 1'b1;
            end
            PH_SP2: begin
                move_to(PH_IDLE, 1'b1, 1'b1);
                fin = 1'b1;
            end
            default: begin
                move_to(PH_IDLE, scl_lvl, sda_lvl);
                fin = 1'b1;
            end
        endcase
        return fin;
    endfunction

    // One tick of the engine: returns the result item it produces
    function automatic t_result line_step(input logic [2:0] op, input logic [7:0] tx,
                                          input logic ack, input logic sda_smp);
        t_result r;
        logic    fin;
        fin = 1'b0;
        if (ph == PH_IDLE) begin
            case (op)
                OP_START: move_to(PH_ST1, 1'b1, 1'b1);
                OP_STOP:  move_to(PH_SP1, 1'b0, 1'b0);
                OP_WRITE: begin
                    shifter = tx;
                    bit_cnt = 4'd0;
                    move_to(PH_WSET, 1'b0, tx[7]);
                end
                OP_READ: begin
                    ack_sel = ack;
                    shifter = 8'd0;
                    bit_cnt = 4'd0;
                    move_to(PH_RLOW, 1'b0, 1'b1);
                end
                default: ;
            endcase
        end else if (ph == PH_POLL) begin
            // low sample is the ACK; too many high samples give up with a stop
            if (!sda_smp) begin
                ack_err = 1'b0;
                move_to(PH_IDLE, 1'b0, 1'b1);
                fin = 1'b1;
            end else if (poll_cnt >= cfg.timeout) begin
                ack_err = 1'b1;
                move_to(PH_SP1, 1'b0, 1'b0);
            end else begin
                poll_cnt = poll_cnt + 8'd1;
            end
        end else begin
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= phase_ticks(ph)) fin = end_phase(sda_smp);
        end
        r.scl_out     = scl_lvl;
        r.sda_out     = sda_lvl;
        r.busy_res    = (ph != PH_IDLE);
        r.done_res    = fin;
        r.rx_byte     = rx_last;
        r.ack_missing = ack_err;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg      = CFG_RESET;
            ph       = ENG_RESET.phase;
            tick_cnt = ENG_RESET.tick_cnt;
            poll_cnt = ENG_RESET.poll_cnt;
            bit_cnt  = ENG_RESET.bit_cnt;
            shifter  = ENG_RESET.shift;
            scl_lvl  = ENG_RESET.scl;
            sda_lvl  = ENG_RESET.sda;
            ack_sel  = ENG_RESET.ack_choice;
            ack_err  = ENG_RESET.ack_error;
            rx_last  = ENG_RESET.rx_hold;
            owed_results.delete();
        end else begin
            // register writes; the spare index is ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SHORT:   cfg.short_len = i_cfg_data;
                    CFG_LONG:    cfg.long_len  = i_cfg_data;
                    CFG_TIMEOUT: cfg.timeout   = i_cfg_data;
                    default: ;
                endcase
            end
            // result first: it belongs to an item taken at an earlier edge
            if (i_res.valid && i_res.ready) begin
                if (owed_results.size() == 0) begin
                    report_error("result item with no item outstanding");
                end else begin
                    want = owed_results.pop_front();
                    check_field("scl_out", 8'(i_res.scl_out), 8'(want.scl_out));
                    check_field("sda_out", 8'(i_res.sda_out), 8'(want.sda_out));
                    check_field("busy_res", 8'(i_res.busy_res), 8'(want.busy_res));
                    check_field("done_res", 8'(i_res.done_res), 8'(want.done_res));
                    check_field("rx_byte", i_res.rx_byte, want.rx_byte);
                    check_field("ack_missing", 8'(i_res.ack_missing), 8'(want.ack_missing));
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                owed_results.push_back(line_step(i_tick.opcode, i_tick.tx_byte,
                                                 i_tick.send_ack, i_tick.sda_in));
            end
        end
        o_busy    <= (ph != PH_IDLE);
        o_pending <= owed_results.size();
        o_err_cnt <= err_n;
    end

endmodule

// File: tb/tb_top.sv
// Top of the I2C master byte engine testbench: clock, reset, stimulus and verdict.
module tb_top;
    import i2cm_pkg::*;

    // Opcodes the engine must ignore, and the register index past the list
    localparam logic [2:0]           OP_RSVD5  = 3'd5;
    localparam logic [2:0]           OP_RSVD6  = 3'd6;
    localparam logic [2:0]           OP_RSVD7  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int RAND_TICKS      = 500;
    localparam int WATCHDOG_CYCLES = 4_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [7:0]           cfg_data;
    int                   err_cnt;
    int                   pending;
    logic                 eng_busy;

    int                   pace_max = 16;
    bit                   calm = 1'b0;
    int                   tick_n = 0;

    i2cm_cmd_if tick_ch();
    i2cm_res_if res_ch();

    i2c_master_byte_engine_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (tick_ch),
        .o_result   (res_ch)
    );

    i2cm_line_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_tick     (tick_ch),
        .i_res      (res_ch),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending),
        .o_busy     (eng_busy)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog
    initial begin
        #(2 * WATCHDOG_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall before each result item
    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            stall = $urandom_range(0, pace_max);
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
        end
    end

    function automatic logic line_sample(input int low_pct);
        return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
    endfunction

    // One tick item; valid stays high afterwards so back-to-back ticks need no gap
    task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                             input logic sda);
        int gap;
        gap = $urandom_range(0, pace_max);
        @(negedge clk);
        if (gap > 0) begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.opcode   = op;
        tick_ch.tx_byte  = tx;
        tick_ch.send_ack = ack;
        tick_ch.sda_in   = sda;
        tick_ch.valid    = 1'b1;
        do @(posedge clk); while (tick_ch.ready !== 1'b1);
        tick_n++;
    endtask

    // Issue a command, then keep ticking until the engine is idle again.
    // eng_busy read at the edge reflects the state before the tick just taken.
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input int low_pct, input bit noisy);
        logic [2:0] extra_op;
        if (calm) begin
            pace_max = 0;
        end else begin
            case ($urandom_range(0, 3))
                0: pace_max = 0;
                1: pace_max = 2;
                default: pace_max = 16;
            endcase
        end
        send_tick(op, tx, ack, line_sample(low_pct));
        do begin
            extra_op = (noisy && $urandom_range(0, 2) == 0) ? 3'($urandom) : OP_NONE;
            send_tick(extra_op, 8'($urandom), 1'($urandom), line_sample(low_pct));
        end while (eng_busy);
    endtask

    // Empty ticks until the engine has finished whatever it was doing
    task automatic drain_engine();
        do send_tick(OP_NONE, 8'h00, 1'b0, 1'($urandom)); while (eng_busy);
    endtask

    // Stop sending and wait for every owed result item
    task automatic hold_until_drained();
        @(negedge clk);
        tick_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    initial begin : stimulus
        int         base_n;
        int         low_pct;
        logic [2:0] op;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_SHORT;
        cfg_data         = 8'h00;
        tick_ch.valid    = 1'b0;
        tick_ch.opcode   = OP_NONE;
        tick_ch.tx_byte  = 8'h00;
        tick_ch.send_ack = 1'b0;
        tick_ch.sda_in   = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset lengths: each command, ACK, missing ACK, both read levels
        run_cmd(OP_START, 8'h00, 1'b0, 50, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, 100, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b0, 0, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b1, 0, 1'b0);
        run_cmd(OP_READ, 8'hFF, 1'b0, 100, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 50, 1'b1);
        run_cmd(OP_RSVD5, 8'hFF, 1'b1, 50, 1'b0);
        run_cmd(OP_RSVD6, 8'h00, 1'b0, 50, 1'b0);
        run_cmd(OP_RSVD7, 8'hFF, 1'b1, 50, 1'b0);
        run_cmd(OP_NONE, 8'h00, 1'b0, 50, 1'b0);

        // Zero lengths and zero timeout; spare index must not land anywhere
        drain_engine();
        hold_until_drained();
        write_reg(CFG_SHORT, 8'h00);
        write_reg(CFG_LONG, 8'h00);
        write_reg(CFG_TIMEOUT, 8'h00);
        write_reg(CFG_SPARE, 8'hFF);
        run_cmd(OP_START, 8'h00, 1'b0, 50, 1'b1);
        run_cmd(OP_WRITE, 8'h81, 1'b0, 0, 1'b0);
        run_cmd(OP_WRITE, 8'h7E, 1'b1, 100, 1'b1);
        run_cmd(OP_READ, 8'h00, 1'b1, 50, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b0, 50, 1'b1);
        run_cmd(OP_STOP, 8'h00, 1'b0, 50, 1'b0);

        // Longest phase length, then longest timeout, no idling to keep the run short
        drain_engine();
        hold_until_drained();
        calm = 1'b1;
        write_reg(CFG_SHORT, 8'hFF);
        write_reg(CFG_LONG, 8'hFF);
        write_reg(CFG_TIMEOUT, 8'hFF);
        run_cmd(OP_STOP, 8'h00, 1'b0, 50, 1'b0);
        drain_engine();
        hold_until_drained();
        write_reg(CFG_SHORT, 8'h00);
        write_reg(CFG_LONG, 8'h00);
        run_cmd(OP_WRITE, 8'h5A, 1'b0, 0, 1'b0);
        calm = 1'b0;

        // Random: mostly short lengths, command sequences with noise in between
        base_n = tick_n;
        while (tick_n - base_n < RAND_TICKS) begin
            drain_engine();
            hold_until_drained();
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_SHORT, ($urandom_range(0, 9) == 0) ?
                          8'($urandom_range(0, 40)) : 8'($urandom_range(0, 4)));
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_LONG, ($urandom_range(0, 9) == 0) ?
                          8'($urandom_range(0, 20)) : 8'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_TIMEOUT, 8'h00);
                    1: write_reg(CFG_TIMEOUT, 8'($urandom_range(1, 8)));
                    2: write_reg(CFG_TIMEOUT, 8'($urandom));
                    default: write_reg(CFG_TIMEOUT, 8'd250);
                endcase
            end
            if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, 8'($urandom));

            repeat ($urandom_range(8, 24)) begin
                // stay near the item budget
                if (tick_n - base_n >= RAND_TICKS) break;
                if ($urandom_range(0, 29) == 0) hold_until_drained();
                case ($urandom_range(0, 11))
                    0, 1:       op = OP_START;
                    2, 3:       op = OP_STOP;
                    4, 5, 6, 7: op = OP_WRITE;
                    8, 9, 10:   op = OP_READ;
                    default:    op = 3'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0: low_pct = 0;
                    1: low_pct = 5;
                    2: low_pct = 50;
                    default: low_pct = 100;
                endcase
                run_cmd(op, 8'($urandom), 1'($urandom), low_pct, 1'($urandom));
            end
        end

        // Wind down: let the last result items arrive, bounded
        @(negedge clk);
        tick_ch.valid = 1'b0;
        repeat (200) begin
            if (pending == 0) break;
            @(negedge clk);
        end
        repeat (4) @(negedge clk);

        if (err_cnt == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/i2cm_pkg.sv
hdl/i2cm_cmd_if.sv
hdl/i2cm_res_if.sv
hdl/i2cm_cfg_regs.sv
hdl/i2cm_step.sv
hdl/i2c_master_byte_engine_unit.sv
tb/i2cm_line_checker.sv
tb/tb_top.sv
